>>> rtl/core/bpw_pkg.sv
// ============================================================================
// bpw_pkg: shared definitions for the blocked progress watchdog
// Operation, status and register codes, field widths, and the command and
// status bundles that join the controller to the datapath.
// ============================================================================
package bpw_pkg;

  // Field widths
  localparam int OPW    = 2;
  localparam int KEYW   = 16;
  localparam int RSNW   = 3;
  localparam int STW    = 3;
  localparam int BNW    = 7;
  localparam int STALLW = 22;
  localparam int SNW    = 6;
  localparam int CFG_IDX_W = 2;

  // Packed stream widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Limits and defaults
  localparam int MAX_LIST      = 64;
  localparam int SLOTS_DEFAULT = 64;
  localparam int TICK_MS_DEFAULT = 500;
  localparam logic [STALLW-1:0] STALL_MAX   = {STALLW{1'b1}};
  localparam logic [STALLW-1:0] TIMEOUT_RST = 22'd10000;

  // Operation codes
  localparam logic [OPW-1:0] OP_TICK     = 2'd0;
  localparam logic [OPW-1:0] OP_ENTER    = 2'd1;
  localparam logic [OPW-1:0] OP_EXIT     = 2'd2;
  localparam logic [OPW-1:0] OP_PROGRESS = 2'd3;

  // Result status codes
  localparam logic [STW-1:0] ST_DONE     = 3'd0;
  localparam logic [STW-1:0] ST_DISABLED = 3'd1;
  localparam logic [STW-1:0] ST_IGNORED  = 3'd2;
  localparam logic [STW-1:0] ST_FULL     = 3'd3;
  localparam logic [STW-1:0] ST_HALTED   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALT_ON_DEAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic           accept;       // latch the input item
    logic           set_progress; // progress mark
    logic           tick;         // run the stall check
    logic           scan_start;   // clear scan index, match and listing state
    logic           scan_chk;     // evaluate the slot at the scan index
    logic           idx_next;     // advance the scan index
    logic           do_enter;     // record the key in the free slot
    logic           do_exit;      // free the matched slot
    logic           emit_single;  // load a single result
    logic           emit_slot;    // load a listing result for the scanned slot
    logic [STW-1:0] status;       // status for a single result
  } bpw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic           halted;
    logic           enable;
    logic [OPW-1:0] op;
    logic           detect;       // this tick reports a deadlock
    logic           match_found;
    logic           free_found;
    logic           scan_end;
    logic           slot_act;     // slot at the scan index is active
    logic           list_last;    // the slot being listed now is the final one
    logic           out_free;     // output register can take a result
  } bpw_stat_t;

endpackage

>>> rtl/core/bpw_ctrl.sv
// ============================================================================
// bpw_ctrl: watchdog controller
// Sequences each item through decode, slot table scan, table update and
// result delivery, and walks the table for a deadlock listing.
// ============================================================================
module bpw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  bpw_pkg::bpw_stat_t  stat,
  output bpw_pkg::bpw_cmd_t   cmd
);
  import bpw_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_APPLY    = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;
  localparam logic [2:0] S_LIST_RD  = 3'd6;
  localparam logic [2:0] S_LIST_CHK = 3'd7;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [STW-1:0] status;
  logic [STW-1:0] status_next;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    s_tready    = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.halted) begin
          status_next = ST_HALTED;
          state_next  = S_EMIT;
        end else if (!stat.enable) begin
          status_next = ST_DISABLED;
          state_next  = S_EMIT;
        end else if (stat.op == OP_PROGRESS) begin
          cmd.set_progress = 1'b1;
          status_next      = ST_DONE;
          state_next       = S_EMIT;
        end else if (stat.op == OP_TICK) begin
          cmd.tick    = 1'b1;
          status_next = ST_DONE;
          if (stat.detect) begin
            cmd.scan_start = 1'b1;
            state_next     = S_LIST_RD;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (stat.scan_end) begin
          state_next = S_APPLY;
        end else begin
          cmd.idx_next = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_APPLY: begin
        state_next = S_EMIT;
        if (stat.op == OP_ENTER) begin
          if (stat.match_found) begin
            status_next = ST_IGNORED;
          end else if (!stat.free_found) begin
            status_next = ST_FULL;
          end else begin
            cmd.do_enter = 1'b1;
            status_next  = ST_DONE;
          end
        end else begin
          if (!stat.match_found) begin
            status_next = ST_IGNORED;
          end else begin
            cmd.do_exit = 1'b1;
            status_next = ST_DONE;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_LIST_RD: begin
        state_next = S_LIST_CHK;
      end
      S_LIST_CHK: begin
        // An active slot is listed once the output register is free.
        if (stat.slot_act) begin
          if (stat.out_free) begin
            cmd.emit_slot = 1'b1;
            if (stat.list_last) begin
              state_next = S_IDLE;
            end else begin
              cmd.idx_next = 1'b1;
              state_next   = S_LIST_RD;
            end
          end
        end else if (stat.scan_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_next = 1'b1;
          state_next   = S_LIST_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_DONE;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

endmodule

>>> rtl/core/bpw_dpath.sv
// ============================================================================
// bpw_dpath: watchdog datapath
// Configuration registers, slot table memory with active bits, blocked
// count, stall timer, detection flags and the registered result stage.
// ============================================================================
module bpw_dpath #(
  parameter int SLOTS   = bpw_pkg::SLOTS_DEFAULT,
  parameter int TICK_MS = bpw_pkg::TICK_MS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpw_pkg::STALLW-1:0]          cfg_data,
  // Input item payload
  input  logic [bpw_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [bpw_pkg::OPW-1:0]             s_tuser,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bpw_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [bpw_pkg::STW-1:0]             m_tuser,
  output logic                                m_tlast,
  // Controller link
  input  bpw_pkg::bpw_cmd_t                   cmd,
  output bpw_pkg::bpw_stat_t                  stat
);
  import bpw_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = $clog2(SLOTS + 1);
  localparam int LW = BW + BNW;
  localparam int LCW = $clog2(MAX_LIST);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Configuration registers
  logic              detect_enable;
  logic              halt_on_deadlock;
  logic [STALLW-1:0] stall_limit;

  // Latched input item
  logic [OPW-1:0]  op;
  logic [KEYW-1:0] key;
  logic [RSNW-1:0] reason;

  // Slot table
  logic [KEYW-1:0] slot_keys [SLOTS];
  logic [RSNW-1:0] slot_reasons [SLOTS];
  logic [SLOTS-1:0] slot_active;
  logic [KEYW-1:0] rd_key;
  logic [RSNW-1:0] rd_reason;

  // Watchdog state
  logic [BW-1:0]     blocked_total;
  logic              progress_seen;
  logic [STALLW-1:0] stall_time;
  logic              already_warned;
  logic              halted;
  logic              abort_flag;

  // Scan state
  logic [IW-1:0]  scan_idx;
  logic           match_found;
  logic [IW-1:0]  match_idx;
  logic           free_found;
  logic [IW-1:0]  free_idx;
  logic [LCW-1:0] list_cnt;

  // Derived values
  logic [STALLW:0]   stall_sum;
  logic [STALLW-1:0] stall_new;
  logic              stalled;
  logic              out_free;
  logic [BNW-1:0]    blocked_now;
  logic              list_last;

  assign cfg_ready = 1'b1;

  // Configuration writes; an index past the list writes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable    <= 1'b0;
      halt_on_deadlock <= 1'b1;
      stall_limit      <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DETECT_ENABLE: detect_enable    <= cfg_data[0];
        REG_HALT_ON_DEAD:  halt_on_deadlock <= cfg_data[0];
        REG_STALL_LIMIT:   stall_limit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input item latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= s_tuser;
      key    <= s_tdata[KEYW-1:0];
      reason <= s_tdata[KEYW+RSNW-1:KEYW];
    end
  end

  // Slot table memory: one write port, one registered read at the scan index.
  always_ff @(posedge clk) begin
    if (cmd.do_enter) begin
      slot_keys[free_idx]    <= key;
      slot_reasons[free_idx] <= reason;
    end
    rd_key    <= slot_keys[scan_idx];
    rd_reason <= slot_reasons[scan_idx];
  end

  // Stall timer arithmetic with saturation.
  assign stall_sum = {1'b0, stall_time} + (STALLW + 1)'(TICK_MS);
  assign stall_new = stall_sum[STALLW] ? STALL_MAX : stall_sum[STALLW-1:0];
  assign stalled   = (blocked_total != '0) && !progress_seen;

  // Active bits, count and watchdog flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active    <= '0;
      blocked_total  <= '0;
      progress_seen  <= 1'b0;
      stall_time     <= '0;
      already_warned <= 1'b0;
      halted         <= 1'b0;
      abort_flag     <= 1'b0;
    end else begin
      if (cmd.do_enter) begin
        slot_active[free_idx] <= 1'b1;
        blocked_total         <= blocked_total + BW'(1);
      end
      if (cmd.do_exit) begin
        slot_active[match_idx] <= 1'b0;
        if (blocked_total != '0) begin
          blocked_total <= blocked_total - BW'(1);
        end
      end
      if (cmd.set_progress) begin
        progress_seen <= 1'b1;
      end
      if (cmd.tick) begin
        progress_seen <= 1'b0;
        if (stalled) begin
          stall_time <= stall_new;
          if (stat.detect) begin
            already_warned <= 1'b1;
            abort_flag     <= halt_on_deadlock;
            if (halt_on_deadlock) begin
              halted <= 1'b1;
            end
          end
        end else begin
          stall_time     <= '0;
          already_warned <= 1'b0;
        end
      end
    end
  end

  // Scan index, key match, first free slot and listing count.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx    <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      list_cnt    <= '0;
    end else begin
      if (cmd.scan_start) begin
        scan_idx    <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        list_cnt    <= '0;
      end
      if (cmd.idx_next) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (cmd.scan_chk) begin
        if (slot_active[scan_idx] && (rd_key == key) && !match_found) begin
          match_found <= 1'b1;
        end
        if (!slot_active[scan_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.emit_slot) begin
        list_cnt <= list_cnt + LCW'(1);
      end
    end
  end

  // Slot positions found by the scan.
  always_ff @(posedge clk) begin
    if (cmd.scan_chk) begin
      if (slot_active[scan_idx] && (rd_key == key) && !match_found) begin
        match_idx <= scan_idx;
      end
      if (!slot_active[scan_idx] && !free_found) begin
        free_idx <= scan_idx;
      end
    end
  end

  // The active slot count equals the blocked count, so the listing ends at
  // whichever comes first: that count or the listing limit.
  assign list_last = (list_cnt == LCW'(MAX_LIST - 1)) ||
                     ((LW'(list_cnt) + LW'(1)) == LW'(blocked_total));

  assign blocked_now = (LW'(blocked_total) > LW'(2**BNW - 1)) ?
                       BNW'(2**BNW - 1) : BNW'(blocked_total);

  // Result register: loads when empty or when the current result is taken.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_slot) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      m_tuser <= cmd.status;
      m_tlast <= 1'b1;
      m_tdata <= {7'd0, RSNW'(0), SNW'(0), 1'b0, 1'b0, 1'b0,
                  stall_time, blocked_now};
    end else if (cmd.emit_slot) begin
      m_tuser <= ST_DONE;
      m_tlast <= list_last;
      m_tdata <= {7'd0, rd_reason, SNW'(scan_idx), 1'b1, abort_flag, 1'b1,
                  stall_time, blocked_now};
    end
  end

  // Status to the controller.
  always_comb begin
    stat             = '0;
    stat.halted      = halted;
    stat.enable      = detect_enable;
    stat.op          = op;
    stat.detect      = stalled && (stall_new >= stall_limit) && !already_warned;
    stat.match_found = match_found;
    stat.free_found  = free_found;
    stat.scan_end    = (scan_idx == LAST_IDX);
    stat.slot_act    = slot_active[scan_idx];
    stat.list_last   = list_last;
    stat.out_free    = out_free;
  end

endmodule

>>> rtl/core/blocked_progress_watchdog.sv
// ============================================================================
// blocked_progress_watchdog: hang detector for blocking requesters
// Tracks requesters that enter and leave blocking waits and reports a
// deadlock when the stall time without progress reaches the timeout.
// ============================================================================
// One item is handled at a time, and its results leave through a registered
// output stage. Tick, progress, disabled and halted items pass from the
// decide state to the emit state, which loads the result. Enter and exit
// items search the slot table one entry at a time, with a read state and a
// check state per entry because the key memory has a registered read port,
// then pass through an apply state to the emit state. A tick that reports a
// deadlock walks the table the same way and lists each active slot. Any
// hold-off on the result side comes on top. The next item is accepted the
// cycle after the final result of the previous one is loaded.
// ============================================================================
module blocked_progress_watchdog #(
  parameter int SLOTS   = bpw_pkg::SLOTS_DEFAULT,
  parameter int TICK_MS = bpw_pkg::TICK_MS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpw_pkg::STALLW-1:0]        cfg_data,
  // Input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // requester_key [15:0], reason_code [18:16], zero fill [23:19]
  input  logic [bpw_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode [1:0]
  input  logic [bpw_pkg::OPW-1:0]           s_tuser,
  // Result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // blocked_now [6:0], stall_time_ms [28:7], deadlock_found [29],
  // abort_raised [30], slot_valid [31], slot_number [37:32],
  // slot_reason [40:38], zero fill [47:41]
  output logic [bpw_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status [2:0]
  output logic [bpw_pkg::STW-1:0]           m_tuser,
  // last
  output logic                              m_tlast
);
  import bpw_pkg::*;

  bpw_cmd_t  cmd;
  bpw_stat_t stat;

  // Controller.
  bpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  bpw_dpath #(
    .SLOTS   (SLOTS),
    .TICK_MS (TICK_MS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> bench/tb_blocked_progress_watchdog.sv
// ============================================================================
// tb_blocked_progress_watchdog: self-checking bench for the hang detector
// Drives enter, exit, progress and tick items over the input stream and
// checks every result item against a cycle-free model of the slot table,
// the stall timer and the once-per-episode deadlock report. A short table of
// directed items runs first, then a table fill, constrained-free random phases,
// a stall under a long timeout, and finally a halting report.
// ============================================================================
module tb_blocked_progress_watchdog;
  import bpw_pkg::*;

  localparam int NSLOT        = SLOTS_DEFAULT;
  localparam int TICK_STEP    = TICK_MS_DEFAULT;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int KEY_POOL_N   = 12;
  localparam int LONG_TICKS   = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // One result item, unpacked into its fields.
  typedef struct packed {
    logic [STW-1:0]    status;
    logic [BNW-1:0]    blocked;
    logic [STALLW-1:0] stall;
    logic              found;
    logic              abrt;
    logic              valid;
    logic [SNW-1:0]    slot;
    logic [RSNW-1:0]   reason;
    logic              last;
  } wd_result_t;

  // One directed item; typed rows carry their single result.
  typedef struct packed {
    logic              reconfig;
    logic [OPW-1:0]    op;
    logic [KEYW-1:0]   key;
    logic [RSNW-1:0]   reason;
    logic              typed;
    logic [STW-1:0]    status;
    logic [BNW-1:0]    blocked;
    logic [STALLW-1:0] stall;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [STALLW-1:0]     cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OPW-1:0]        s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STW-1:0]        m_tuser;
  logic                  m_tlast;

  // Tracker copy of the block state and its registers.
  logic [KEYW-1:0] trk_key    [NSLOT];
  logic [RSNW-1:0] trk_reason [NSLOT];
  bit              trk_active [NSLOT];
  int unsigned     trk_blocked;
  bit              trk_progress;
  int unsigned     trk_stall;
  bit              trk_warned;
  bit              trk_halted;
  bit              trk_enable;
  bit              trk_halt;
  int unsigned     trk_timeout;

  wd_result_t      pending_results [$];
  logic [KEYW-1:0] key_pool [KEY_POOL_N];
  dir_row_t        dir_rows [0:19];
  int              errors = 0;
  bit              idle_on = 1'b1;
  bit              pressure_req = 1'b0;

  blocked_progress_watchdog dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A single result carrying only status and the counters.
  function automatic wd_result_t single_result(logic [STW-1:0] status);
    wd_result_t r;
    r         = '0;
    r.status  = status;
    r.blocked = (trk_blocked > 127) ? 7'd127 : BNW'(trk_blocked);
    r.stall   = STALLW'(trk_stall);
    r.last    = 1'b1;
    return r;
  endfunction

  // Advance the tracker by one accepted item and queue its results.
  function automatic void predict_results(logic [OPW-1:0] op, logic [KEYW-1:0] key,
                                          logic [RSNW-1:0] rsn);
    wd_result_t  r;
    int          hit;
    int          free_slot;
    int          n;
    int unsigned t;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    if (trk_halted) begin
      pending_results.push_back(single_result(ST_HALTED));
      return;
    end
    if (!trk_enable) begin
      pending_results.push_back(single_result(ST_DISABLED));
      return;
    end
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (trk_active[i] && trk_key[i] == key) hit = i;
      if (!trk_active[i]) free_slot = i;
    end
    case (op)
      OP_ENTER: begin
        if (hit >= 0) begin
          pending_results.push_back(single_result(ST_IGNORED));
        end else if (free_slot < 0) begin
          pending_results.push_back(single_result(ST_FULL));
        end else begin
          trk_key[free_slot]    = key;
          trk_reason[free_slot] = rsn;
          trk_active[free_slot] = 1'b1;
          trk_blocked++;
          pending_results.push_back(single_result(ST_DONE));
        end
      end
      OP_EXIT: begin
        if (hit < 0) begin
          pending_results.push_back(single_result(ST_IGNORED));
        end else begin
          trk_active[hit] = 1'b0;
          if (trk_blocked > 0) trk_blocked--;
          pending_results.push_back(single_result(ST_DONE));
        end
      end
      OP_PROGRESS: begin
        trk_progress = 1'b1;
        pending_results.push_back(single_result(ST_DONE));
      end
      default: begin
        if (trk_blocked > 0 && !trk_progress) begin
          // Stalled interval: the timer grows and saturates.
          t         = trk_stall + TICK_STEP;
          trk_stall = (t > STALL_MAX) ? STALL_MAX : t;
          if (trk_stall >= trk_timeout && !trk_warned) begin
            // First report of this episode lists every active slot.
            trk_warned = 1'b1;
            if (trk_halt) trk_halted = 1'b1;
            for (int i = 0; i < NSLOT; i++) begin
              if (trk_active[i] && n < MAX_LIST) begin
                r        = single_result(ST_DONE);
                r.found  = 1'b1;
                r.abrt   = trk_halt;
                r.valid  = 1'b1;
                r.slot   = SNW'(i);
                r.reason = trk_reason[i];
                r.last   = 1'b0;
                pending_results.push_back(r);
                n++;
              end
            end
            if (n == 0) begin
              r       = single_result(ST_DONE);
              r.found = 1'b1;
              r.abrt  = trk_halt;
              r.last  = 1'b0;
              pending_results.push_back(r);
            end
            pending_results[pending_results.size() - 1].last = 1'b1;
          end else begin
            pending_results.push_back(single_result(ST_DONE));
          end
        end else begin
          // Nothing blocked or progress seen: the episode ends.
          trk_stall  = 0;
          trk_warned = 1'b0;
          pending_results.push_back(single_result(ST_DONE));
        end
        trk_progress = 1'b0;
      end
    endcase
  endfunction

  // Offer one input item, with an optional gap first, and predict on acceptance.
  task automatic send_item(logic [OPW-1:0] op, logic [KEYW-1:0] key, logic [RSNW-1:0] rsn,
                           bit use_typed, wd_result_t typed);
    int gap;
    int depth;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, rsn, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    depth = pending_results.size();
    predict_results(op, key, rsn);
    if (use_typed) begin
      while (pending_results.size() > depth) void'(pending_results.pop_back());
      pending_results.push_back(typed);
    end
  endtask

  task automatic send_plain(logic [OPW-1:0] op, logic [KEYW-1:0] key, logic [RSNW-1:0] rsn);
    send_item(op, key, rsn, 1'b0, '0);
  endtask

  // Write one register and keep the tracker's copy in step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STALLW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DETECT_ENABLE: trk_enable  = val[0];
      REG_HALT_ON_DEAD:  trk_halt    = val[0];
      REG_STALL_LIMIT:   trk_timeout = val;
      default: ;
    endcase
  endtask

  task automatic set_config(bit en, bit halt, int unsigned tmo);
    write_reg(REG_DETECT_ENABLE, STALLW'(en));
    write_reg(REG_HALT_ON_DEAD, STALLW'(halt));
    write_reg(REG_STALL_LIMIT, STALLW'(tmo));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every result, then let the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random mix over a small key pool so that exits and repeats find their slots.
  task automatic send_random(int count);
    int unsigned     pick;
    logic [OPW-1:0]  op;
    logic [KEYW-1:0] key;
    logic [RSNW-1:0] rsn;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_ENTER;
      else if (pick < 55) op = OP_EXIT;
      else if (pick < 85) op = OP_TICK;
      else                op = OP_PROGRESS;
      if ($urandom_range(0, 9) == 0) key = KEYW'($urandom);
      else                           key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
      if ($urandom_range(0, 7) == 0) rsn = RSNW'($urandom_range(5, 7));
      else                           rsn = RSNW'($urandom_range(0, 4));
      send_plain(op, key, rsn);
    end
  endtask

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endtask

  // Compare one accepted result item with the oldest expectation.
  task automatic check_result();
    wd_result_t e;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result item, expected none, actual status %0d data %h",
               $time, m_tuser, m_tdata);
    end else begin
      e = pending_results.pop_front();
      check_field("status", e.status, m_tuser);
      check_field("blocked_now", e.blocked, m_tdata[6:0]);
      check_field("stall_time_ms", e.stall, m_tdata[28:7]);
      check_field("deadlock_found", e.found, m_tdata[29]);
      check_field("abort_raised", e.abrt, m_tdata[30]);
      check_field("slot_valid", e.valid, m_tdata[31]);
      check_field("slot_number", e.slot, m_tdata[37:32]);
      check_field("slot_reason", e.reason, m_tdata[40:38]);
      check_field("last", e.last, m_tlast);
    end
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    bit pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    m_tready      = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_result();
      if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        stall_left    = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin : run_limit
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    wd_result_t typed;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_TICK;

    // Tracker reset state.
    for (int i = 0; i < NSLOT; i++) begin
      trk_key[i]    = '0;
      trk_reason[i] = '0;
      trk_active[i] = 1'b0;
    end
    trk_blocked  = 0;
    trk_progress = 1'b0;
    trk_stall    = 0;
    trk_warned   = 1'b0;
    trk_halted   = 1'b0;
    trk_enable   = 1'b0;
    trk_halt     = 1'b1;
    trk_timeout  = TIMEOUT_RST;
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = KEYW'($urandom);

    // Disabled after reset, then a zero timeout so that the first stall reports.
    dir_rows = '{
      '{1'b0, OP_TICK,     16'h0000, 3'd0, 1'b1, ST_DISABLED, 7'd0, 22'd0},
      '{1'b0, OP_ENTER,    16'hFFFF, 3'd7, 1'b1, ST_DISABLED, 7'd0, 22'd0},
      '{1'b0, OP_EXIT,     16'hFFFF, 3'd0, 1'b1, ST_DISABLED, 7'd0, 22'd0},
      '{1'b0, OP_PROGRESS, 16'h0000, 3'd0, 1'b1, ST_DISABLED, 7'd0, 22'd0},
      '{1'b1, OP_TICK,     16'h0000, 3'd0, 1'b1, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_ENTER,    16'h0000, 3'd0, 1'b1, ST_DONE,     7'd1, 22'd0},
      '{1'b0, OP_ENTER,    16'hFFFF, 3'd4, 1'b1, ST_DONE,     7'd2, 22'd0},
      '{1'b0, OP_ENTER,    16'h0000, 3'd3, 1'b1, ST_IGNORED,  7'd2, 22'd0},
      '{1'b0, OP_EXIT,     16'h1234, 3'd0, 1'b1, ST_IGNORED,  7'd2, 22'd0},
      '{1'b0, OP_ENTER,    16'h5A5A, 3'd7, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_PROGRESS, 16'h0000, 3'd0, 1'b1, ST_DONE,     7'd3, 22'd0},
      '{1'b0, OP_TICK,     16'h0000, 3'd0, 1'b1, ST_DONE,     7'd3, 22'd0},
      '{1'b0, OP_TICK,     16'h0000, 3'd0, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_TICK,     16'h0000, 3'd0, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_EXIT,     16'h0000, 3'd0, 1'b1, ST_DONE,     7'd2, 22'd1000},
      '{1'b0, OP_EXIT,     16'h0000, 3'd0, 1'b1, ST_IGNORED,  7'd2, 22'd1000},
      '{1'b0, OP_TICK,     16'hA5A5, 3'd5, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_EXIT,     16'hFFFF, 3'd0, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_EXIT,     16'h5A5A, 3'd0, 1'b0, ST_DONE,     7'd0, 22'd0},
      '{1'b0, OP_TICK,     16'h0000, 3'd0, 1'b1, ST_DONE,     7'd0, 22'd0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].reconfig) begin
        wait_idle();
        write_reg(CFG_IDX_SPARE, STALLW'($urandom));
        set_config(1'b1, 1'b0, 0);
      end
      typed         = '0;
      typed.status  = dir_rows[i].status;
      typed.blocked = dir_rows[i].blocked;
      typed.stall   = dir_rows[i].stall;
      typed.last    = 1'b1;
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].reason, dir_rows[i].typed, typed);
    end

    // Fill the table, overflow it, and list every slot on the report.
    wait_idle();
    set_config(1'b1, 1'b0, 1000);
    for (int i = 0; i < NSLOT + 1; i++)
      send_plain(OP_ENTER, KEYW'(16'h8000 + i * 97), RSNW'($urandom_range(0, 4)));
    send_plain(OP_ENTER, 16'h8000, 3'd1);
    repeat (3) send_plain(OP_TICK, KEYW'($urandom), RSNW'($urandom));
    for (int i = 0; i < NSLOT + 1; i++)
      send_plain(OP_EXIT, KEYW'(16'h8000 + i * 97), 3'd0);
    send_plain(OP_TICK, 16'h0000, 3'd0);

    // Random phases over several settings.
    wait_idle();
    set_config(1'b1, 1'b0, 1000);
    send_random(80);
    wait_idle();
    set_config(1'b1, 1'b0, 0);
    pressure_req = 1'b1;
    send_random(80);
    wait_idle();
    set_config(1'b0, 1'b0, TIMEOUT_RST);
    send_random(30);
    wait_idle();
    set_config(1'b1, 1'b0, $urandom_range(1000, 4000));
    send_random(80);

    // Stall under a long timeout that these ticks never reach; no idling from here.
    wait_idle();
    idle_on = 1'b0;
    set_config(1'b1, 1'b0, 3600000);
    send_plain(OP_PROGRESS, 16'h0000, 3'd0);
    send_plain(OP_TICK, 16'h0000, 3'd0);
    send_plain(OP_ENTER, 16'hC3C3, 3'd2);
    for (int i = 0; i < LONG_TICKS; i++) send_plain(OP_TICK, KEYW'($urandom), RSNW'($urandom));

    // New episode with halting: the report freezes the block for good.
    send_plain(OP_PROGRESS, 16'h0000, 3'd0);
    send_plain(OP_TICK, 16'h0000, 3'd0);
    wait_idle();
    set_config(1'b1, 1'b1, 1000);
    repeat (3) send_plain(OP_TICK, 16'h0000, 3'd0);
    send_plain(OP_ENTER, 16'h7777, 3'd3);
    send_plain(OP_EXIT, 16'hC3C3, 3'd0);
    send_plain(OP_PROGRESS, 16'h0000, 3'd0);
    wait_idle();
    set_config(1'b0, 1'b1, 1000);
    send_plain(OP_TICK, 16'h0000, 3'd0);
    send_plain(OP_ENTER, 16'h1111, 3'd1);

    // Drain and settle.
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
